[design/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// shared types, state codes and the start-state matrix of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

	localparam int CHAN_W   = 12;
	localparam int TICKS_W  = 8;
	localparam int SEL_W    = 2;
	localparam int OUT_CNT_W = 7;
	localparam int STATE_W  = 4;
	localparam int BLEND_W  = 8;
	localparam int TIMER_W  = 16;
	localparam int CFG_W    = 7;

	// channel thresholds
	localparam logic signed [CHAN_W-1:0] CHAN_HI = 12'sd500;
	localparam logic signed [CHAN_W-1:0] CHAN_LO = -12'sd500;

	// profile codes
	localparam logic [SEL_W-1:0] PROF_P1      = 2'd0;
	localparam logic [SEL_W-1:0] PROF_P1N     = 2'd1;
	localparam logic [SEL_W-1:0] PROF_P2      = 2'd2;
	localparam logic [SEL_W-1:0] PROF_STARTUP = 2'd3;

	// sequencer state codes
	localparam logic [STATE_W-1:0] ST_P1     = 4'd0;
	localparam logic [STATE_W-1:0] ST_P1N    = 4'd1;
	localparam logic [STATE_W-1:0] ST_P2     = 4'd2;
	localparam logic [STATE_W-1:0] ST_TRANS  = 4'd3;
	localparam logic [STATE_W-1:0] ST_P1_P1N = 4'd4;
	localparam logic [STATE_W-1:0] ST_P1N_P1 = 4'd5;
	localparam logic [STATE_W-1:0] ST_P2_P1  = 4'd6;
	localparam logic [STATE_W-1:0] ST_P1_P2  = 4'd7;
	localparam logic [STATE_W-1:0] ST_P1N_P2 = 4'd8;
	localparam logic [STATE_W-1:0] ST_P2_P1N = 4'd9;

	// register indexes
	localparam logic CFG_IDX_SPEED = 1'b0;
	localparam logic CFG_IDX_MID   = 1'b1;

	localparam logic [CFG_W-1:0] SPEED_RESET = 7'd0;
	localparam logic [CFG_W-1:0] MID_RESET   = 7'd50;

	typedef struct packed {
		logic [CFG_W-1:0] speed;
		logic [CFG_W-1:0] mid;
	} cfg_t;

	typedef struct packed {
		logic signed [CHAN_W-1:0] chan;
		logic [TICKS_W-1:0]       ticks;
	} item_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [BLEND_W-1:0] blend;
		logic [SEL_W-1:0]   prev_prof;
		logic [CFG_W-1:0]   prev_speed;
		logic [TIMER_W-1:0] timer;
	} seq_t;

	typedef struct packed {
		logic [STATE_W-1:0]   state;
		logic [OUT_CNT_W-1:0] blend;
		logic [SEL_W-1:0]     sel;
	} result_t;

	// start state on a target change, rows by new target, columns by old
	function automatic logic [STATE_W-1:0] start_of(input logic [SEL_W-1:0] sel,
		input logic [SEL_W-1:0] prev);
		logic [STATE_W-1:0] st;
		st = ST_TRANS;
		unique case ({sel, prev})
			{PROF_P1, PROF_P1N}:  st = ST_P1N_P1;
			{PROF_P1, PROF_P2}:   st = ST_P2_P1;
			{PROF_P1N, PROF_P1}:  st = ST_P1_P1N;
			{PROF_P1N, PROF_P2}:  st = ST_P2_P1N;
			{PROF_P2, PROF_P1}:   st = ST_P1_P2;
			{PROF_P2, PROF_P1N}:  st = ST_P1N_P2;
			default:              st = ST_TRANS;
		endcase
		return st;
	endfunction

endpackage

`default_nettype wire

[design/pts_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pts_cfg_regs
// configuration register file: step speed and midpoint position
// ----------------------------------------------------------------------------
`default_nettype none

module pts_cfg_regs
	import pts_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic             wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed <= SPEED_RESET;
			cfg_q.mid   <= MID_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_IDX_SPEED: cfg_q.speed <= wr_data;
				CFG_IDX_MID:   cfg_q.mid   <= wr_data;
				default:       cfg_q.speed <= cfg_q.speed;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/pts_step_logic.sv]
// ----------------------------------------------------------------------------
// pts_step_logic
// next-state and result logic for one item, purely combinational
// ----------------------------------------------------------------------------
`default_nettype none

module pts_step_logic
	import pts_pkg::*;
#(
	parameter int TICKS_PER_UNIT = 195,
	parameter int FULL_SCALE     = 100
) (
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire seq_t  cur,
	output seq_t       nxt,
	output result_t    res
);

	localparam int MAX_SPEED = (1 << CFG_W) - 1;
	localparam int PERIOD_W  = $clog2(TICKS_PER_UNIT * MAX_SPEED + 1);
	localparam int CMP_W     = (PERIOD_W > TIMER_W) ? PERIOD_W : TIMER_W;
	localparam int CNT_W     = BLEND_W + 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FULL_SCALE);
	localparam logic [PERIOD_W-1:0] TPU = PERIOD_W'(TICKS_PER_UNIT);

	logic [SEL_W-1:0]    sel;
	logic                snap;
	logic                changed;
	logic                step;
	logic [STATE_W-1:0]  st;
	logic [BLEND_W-1:0]  blend;
	logic [SEL_W-1:0]    prev;
	logic [TIMER_W-1:0]  timer_sum;
	logic [PERIOD_W-1:0] period;
	logic [CNT_W-1:0]    cnt;
	logic [CNT_W-1:0]    mid_cnt;

	assign mid_cnt = {2'b00, cfg.mid};

	// constant times a 7-bit speed
	assign period = TPU * PERIOD_W'(cfg.speed);

	always_comb begin
		if (item.chan > CHAN_HI) sel = PROF_P2;
		else if (item.chan > CHAN_LO) sel = PROF_P1N;
		else sel = PROF_P1;
	end

	always_comb begin
		snap  = (cur.prev_prof == PROF_STARTUP) || (cur.prev_speed != cfg.speed);
		st    = cur.state;
		blend = cur.blend;
		prev  = cur.prev_prof;
		if (snap) begin
			prev = sel;
			unique case (sel)
				PROF_P1: begin
					st    = ST_P1;
					blend = '0;
				end
				PROF_P1N: begin
					st    = ST_P1N;
					blend = {1'b0, cfg.mid};
				end
				default: begin
					st    = ST_P2;
					blend = BLEND_W'(FULL_SCALE);
				end
			endcase
		end
		changed = (sel != prev);
		if (cfg.speed == '0) st = ST_TRANS;
		timer_sum = cur.timer + TIMER_W'(item.ticks);
		if (changed) st = start_of(sel, prev);
		step = changed || ((cfg.speed != '0) &&
			(CMP_W'(timer_sum) > CMP_W'(period)));

		// one step of the blend counter
		cnt = {1'b0, blend};
		if (step) begin
			unique case (st)
				ST_P1:   cnt = '0;
				ST_P1N:  cnt = mid_cnt;
				ST_P2:   cnt = FULL_CNT;
				default: cnt = {1'b0, blend};
			endcase
			// approach to the midpoint from the wrong side
			if (st == ST_P1_P1N && cnt > mid_cnt) st = ST_P2_P1N;
			else if (st == ST_P2_P1N && cnt < mid_cnt) st = ST_P1_P1N;

			unique case (st)
				ST_P1N_P1, ST_P2_P1: begin
					if (cnt <= CNT_W'(1)) begin
						cnt = '0;
						st  = ST_P1;
					end else cnt = cnt - CNT_W'(1);
				end
				ST_P1_P1N: begin
					if (cnt + CNT_W'(1) >= mid_cnt) begin
						cnt = mid_cnt;
						st  = ST_P1N;
					end else cnt = cnt + CNT_W'(1);
				end
				ST_P2_P1N: begin
					if (cnt <= mid_cnt + CNT_W'(1)) begin
						cnt = mid_cnt;
						st  = ST_P1N;
					end else cnt = cnt - CNT_W'(1);
				end
				ST_P1N_P2, ST_P1_P2: begin
					if (cnt + CNT_W'(1) >= FULL_CNT) begin
						cnt = FULL_CNT;
						st  = ST_P2;
					end else cnt = cnt + CNT_W'(1);
				end
				default: cnt = cnt;
			endcase
		end

		nxt.state      = st;
		nxt.blend      = cnt[BLEND_W-1:0];
		nxt.prev_prof  = sel;
		nxt.prev_speed = snap ? cfg.speed : cur.prev_speed;
		nxt.timer      = step ? '0 : timer_sum;

		res.sel   = sel;
		res.blend = cnt[OUT_CNT_W-1:0];
		res.state = st;
	end

endmodule

`default_nettype wire

[design/profile_transition_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// profile_transition_sequencer_unit
// picks a target profile from the selection channel and walks the blend
// counter and transition state toward it, one result beat per input beat
// ----------------------------------------------------------------------------
//
//   channel   direction  beat contents
//   s_*       in         flight_channel, elapsed_ticks
//   m_*       out        profile_select, blend_counter, trans_state
//   cfg_*     in         register index 0 transition_speed, 1 midpoint_position
//
// one beat is accepted every cycle while the result register can move on; a
// result passes the input register, then the next-state logic feeding the
// result register, where the sequencer state is updated in the same edge
// the sequencer state and the valid flags of the input and output stages reset
// asynchronously; configuration resets to speed 0 and midpoint 50
// a stalled m_tready holds the result register; the input register still
// takes one more beat, after which s_tready drops until the result moves
// ----------------------------------------------------------------------------
`default_nettype none

module profile_transition_sequencer_unit
	import pts_pkg::*;
#(
	parameter int TICKS_PER_UNIT = 195,
	parameter int FULL_SCALE     = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input beat
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [11:0] flight_channel, [19:12] elapsed_ticks
	// result beat
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [1:0] profile_select, [8:2] blend_counter,
	                                    // [12:9] trans_state
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    valid_s2;
	result_t res_s2;
	seq_t    seq_q;
	seq_t    seq_nxt;
	result_t res_nxt;
	logic    advance;

	// registers accept a write on any cycle
	assign cfg_ready = 1'b1;

	pts_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the beat in the input register moves on when the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.chan  <= s_tdata[11:0];
			item_s1.ticks <= s_tdata[19:12];
		end
	end

	pts_step_logic #(
		.TICKS_PER_UNIT (TICKS_PER_UNIT),
		.FULL_SCALE     (FULL_SCALE)
	) u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (seq_q),
		.nxt  (seq_nxt),
		.res  (res_nxt)
	);

	// sequencer state moves only when an item is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q.state      <= ST_P1;
			seq_q.blend      <= '0;
			seq_q.prev_prof  <= PROF_STARTUP;
			seq_q.prev_speed <= '0;
			seq_q.timer      <= '0;
		end else if (advance) begin
			seq_q <= seq_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.state, res_s2.blend, res_s2.sel};

endmodule

`default_nettype wire
